>>> design/arphb_pkg.sv
// Shared types and constants for the ARP resolver / IPv4 header builder.
// No dependencies.
package arphb_pkg;

    localparam logic [1:0]  KIND_ARP_REQ   = 2'd0;
    localparam logic [1:0]  KIND_ARP_REPLY = 2'd1;
    localparam logic [1:0]  KIND_IPV4_HDR  = 2'd2;

    localparam logic [7:0]  ARP_HW_ETH     = 8'h01;
    localparam logic [15:0] ARP_PROTO_IPV4 = 16'h0800;
    localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;
    localparam logic [15:0] ARP_OP_REPLY   = 16'h0002;

    localparam logic [15:0] IP_VER_IHL     = 16'h4500;
    localparam logic [15:0] IP_FLAGS_DF    = 16'h4000;
    localparam logic [15:0] IP_HDR_BYTES   = 16'd20;
    localparam logic [31:0] IP_BCAST       = 32'hFFFF_FFFF;
    localparam logic [47:0] MAC_BCAST      = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0]  CFG_DEVICE_IP  = 2'd0;
    localparam logic [1:0]  CFG_DEVICE_MAC = 2'd1;
    localparam logic [1:0]  CFG_TTL        = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [7:0]  hw_type_low;
        logic [15:0] proto_type;
        logic [15:0] arp_opcode;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [7:0]  ip_protocol;
        logic [31:0] target_ip;
        logic [15:0] payload_length;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] dest_mac;
        logic [31:0] dest_ip;
        logic [15:0] total_length;
        logic [15:0] ident;
        logic [7:0]  protocol_out;
        logic [15:0] checksum;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [31:0] device_ip;
        logic [47:0] device_mac;
        logic [7:0]  hop_limit;
    } t_cfg;

endpackage

>>> design/arphb_in_if.sv
// Input channel: valid/ready with one parsed item per beat.
// Depends on arphb_pkg.
interface arphb_in_if
    import arphb_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/arphb_out_if.sv
// Result channel: valid/ready with one result per beat.
// Depends on arphb_pkg.
interface arphb_out_if
    import arphb_pkg::*;
();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/arphb_core.sv
// Cache/pending state and result generation for one item per fire.
// Depends on arphb_pkg.
module arphb_core
    import arphb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  t_in_item   i_item,
    input  t_cfg       i_cfg,
    output t_result    o_res0,
    output t_result    o_res1,
    output logic [1:0] o_count
);

    logic        r_pending;
    logic [31:0] r_cached_ip;
    logic [47:0] r_cached_mac;
    logic [15:0] r_next_ident;

    logic        n_pending;
    logic [31:0] n_cached_ip;
    logic [47:0] n_cached_mac;
    logic [15:0] n_next_ident;

    logic        arp_ok;
    logic        bcast;
    logic        send_req;
    logic [31:0] ip_a;
    logic [47:0] mac_a;
    logic [15:0] tlen;
    logic [19:0] sum;
    logic [16:0] fold1;
    logic [16:0] fold2;
    t_result     arp_res;
    t_result     hdr_res;

    always_comb begin
        arp_ok   = (i_item.hw_type_low == ARP_HW_ETH)
                && (i_item.proto_type == ARP_PROTO_IPV4);
        bcast    = (i_item.target_ip == IP_BCAST);
        ip_a     = bcast ? IP_BCAST : r_cached_ip;
        mac_a    = bcast ? MAC_BCAST : r_cached_mac;
        send_req = (i_item.target_ip != ip_a) && !r_pending;
        n_cached_ip = send_req ? i_item.target_ip : ip_a;
        tlen     = i_item.payload_length + IP_HDR_BYTES;

        sum = 20'(IP_VER_IHL) + 20'(tlen) + 20'(r_next_ident) + 20'(IP_FLAGS_DF)
            + 20'({i_cfg.hop_limit, i_item.ip_protocol})
            + 20'(i_cfg.device_ip[31:16]) + 20'(i_cfg.device_ip[15:0])
            + 20'(n_cached_ip[31:16]) + 20'(n_cached_ip[15:0]);
        fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
        fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);

        arp_res.kind         = KIND_ARP_REQ;
        arp_res.dest_mac     = MAC_BCAST;
        arp_res.dest_ip      = i_item.target_ip;
        arp_res.total_length = '0;
        arp_res.ident        = '0;
        arp_res.protocol_out = '0;
        arp_res.checksum     = '0;
        arp_res.last         = 1'b0;

        hdr_res.kind         = KIND_IPV4_HDR;
        hdr_res.dest_mac     = mac_a;
        hdr_res.dest_ip      = n_cached_ip;
        hdr_res.total_length = tlen;
        hdr_res.ident        = r_next_ident;
        hdr_res.protocol_out = i_item.ip_protocol;
        hdr_res.checksum     = ~fold2[15:0];
        hdr_res.last         = 1'b1;

        o_res0       = hdr_res;
        o_res1       = hdr_res;
        o_count      = 2'd0;
        n_pending    = r_pending;
        n_cached_mac = r_cached_mac;
        n_next_ident = r_next_ident;

        if (!i_item.mode) begin
            n_cached_ip = r_cached_ip;
            if (arp_ok && i_item.arp_opcode == ARP_OP_REQUEST) begin
                o_res0.kind         = KIND_ARP_REPLY;
                o_res0.dest_mac     = i_item.sender_mac;
                o_res0.dest_ip      = i_item.sender_ip;
                o_res0.total_length = '0;
                o_res0.ident        = '0;
                o_res0.protocol_out = '0;
                o_res0.checksum     = '0;
                o_res0.last         = 1'b1;
                o_count             = 2'd1;
            end else if (arp_ok && i_item.arp_opcode == ARP_OP_REPLY && r_pending
                         && i_item.sender_ip == r_cached_ip) begin
                n_cached_mac = i_item.sender_mac;
                n_pending    = 1'b0;
            end
        end else begin
            n_cached_mac = mac_a;
            n_pending    = r_pending | send_req;
            n_next_ident = r_next_ident + 16'd1;
            if (send_req) begin
                o_res0  = arp_res;
                o_count = 2'd2;
            end else begin
                o_count = 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending    <= 1'b0;
            r_cached_ip  <= '0;
            r_cached_mac <= MAC_BCAST;
            r_next_ident <= '0;
        end else if (i_fire) begin
            r_pending    <= n_pending;
            r_cached_ip  <= n_cached_ip;
            r_cached_mac <= n_cached_mac;
            r_next_ident <= n_next_ident;
        end
    end

endmodule

>>> design/arphb_outq.sv
// Two-entry result buffer; loads one or two results at once when drained.
// Depends on arphb_pkg and arphb_out_if.
module arphb_outq
    import arphb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic [1:0]  i_count,
    input  t_result     i_res0,
    input  t_result     i_res1,
    output logic        o_room,
    arphb_out_if.source o_result
);

    logic [1:0] r_count;
    t_result    r_slot0;
    t_result    r_slot1;
    logic       pop;

    assign pop            = (r_count != 2'd0) && o_result.ready;
    assign o_room         = (r_count == 2'd0) || (r_count == 2'd1 && pop);
    assign o_result.valid = (r_count != 2'd0);
    assign o_result.data  = r_slot0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (i_push) begin
            r_count <= i_count;
        end else if (pop) begin
            r_count <= r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot0 <= i_res0;
            r_slot1 <= i_res1;
        end else if (pop) begin
            r_slot0 <= r_slot1;
        end
    end

endmodule

>>> design/arp_resolver_ipv4_header_builder.sv
// Top level: input register, config registers, core and result buffer.
// Depends on arphb_pkg, arphb_in_if, arphb_out_if, arphb_core, arphb_outq.
//
//   channel   dir  handshake      beat
//   i_item    in   valid/ready    one parsed ARP packet or send request
//   o_result  out  valid/ready    one ARP request, ARP reply or IPv4 header
//   i_cfg_*   in   write enable   one register write (0 ip, 1 mac, 2 ttl)
//
// An item is registered, then the core's results load into the result buffer.
// Items with one or no result sustain one per cycle while the sink is ready; a
// send with ARP request plus header holds the next item until the buffer drains.
// Synchronous active-low reset clears cached IP, pending flag, ident and valids,
// sets the cached MAC to broadcast; input ready is low while reset is asserted.
// A stalled sink holds results in the buffer; once the input register is
// also full, input ready drops until the buffer drains.
module arp_resolver_ipv4_header_builder
    import arphb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    arphb_in_if.sink    i_item,
    arphb_out_if.source o_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    logic       r_in_valid;
    t_in_item   r_item;
    t_cfg       r_cfg;
    logic       fire;
    logic       room;
    t_result    res0;
    t_result    res1;
    logic [1:0] res_count;

    assign fire         = r_in_valid && room;
    assign i_item.ready = i_rst_n && (!r_in_valid || fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_item <= i_item.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_ip  <= 32'd3232235793;
            r_cfg.device_mac <= '0;
            r_cfg.hop_limit  <= 8'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEVICE_IP:  r_cfg.device_ip  <= i_cfg_data[31:0];
                CFG_DEVICE_MAC: r_cfg.device_mac <= i_cfg_data;
                CFG_TTL:        r_cfg.hop_limit  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    arphb_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_res0  (res0),
        .o_res1  (res1),
        .o_count (res_count)
    );

    arphb_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (fire),
        .i_count  (res_count),
        .i_res0   (res0),
        .i_res1   (res1),
        .o_room   (room),
        .o_result (o_result)
    );

endmodule

>>> tb/tb_arp_resolver_ipv4_header_builder.sv
`timescale 1ns / 1ps
// Self-checking testbench for arp_resolver_ipv4_header_builder: directed table, then
// random ARP/send traffic with valid/ready stalls, checked against an in-bench predictor.
// Depends on arphb_pkg, arphb_in_if, arphb_out_if and the design top level.
module tb_arp_resolver_ipv4_header_builder;
    import arphb_pkg::*;

    localparam logic MODE_ARP_RX = 1'b0;
    localparam logic MODE_IP_TX  = 1'b1;
    localparam int   PREDICTED   = -1;
    localparam int   SETTLE      = 8;
    localparam int   CYCLE_LIMIT = 1_000_000;

    typedef struct {
        t_in_item it;
        int       n;
        t_result  r;
    } t_dir_row;

    typedef struct {
        int      n;
        t_result r;
    } t_typed_note;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [47:0] i_cfg_data;

    arphb_in_if  item_if ();
    arphb_out_if res_if ();

    arp_resolver_ipv4_header_builder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_if),
        .o_result    (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor copy of registers and cache
    logic [31:0] cfg_ip      = 32'hC0A8_0111;
    logic [47:0] cfg_mac     = '0;
    logic [7:0]  cfg_ttl     = 8'd64;
    logic        m_pending   = 1'b0;
    logic [31:0] m_cache_ip  = '0;
    logic [47:0] m_cache_mac = MAC_BCAST;
    logic [15:0] m_ident     = '0;

    t_result     frames_due [$];
    t_typed_note typed_notes [$];
    t_dir_row    dir_rows [$];
    logic [31:0] ip_pool [4];

    int err_cnt      = 0;
    int cycle_cnt    = 0;
    bit hold_req     = 1'b0;
    bit sink_idle_on = 1'b0;
    bit src_idle_on  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("arp_resolver_ipv4_header_builder: mismatch");
            $finish;
        end
    end

    function automatic logic [15:0] hdr_csum(input logic [15:0] tlen, input logic [15:0] id,
                                             input logic [7:0] prot, input logic [31:0] dst);
        logic [31:0] acc;
        acc = 32'(IP_VER_IHL) + 32'(tlen) + 32'(id) + 32'(IP_FLAGS_DF)
            + 32'({cfg_ttl, prot})
            + 32'(cfg_ip[31:16]) + 32'(cfg_ip[15:0]) + 32'(dst[31:16]) + 32'(dst[15:0]);
        acc = 32'(acc[15:0]) + 32'(acc[31:16]);
        acc = 32'(acc[15:0]) + 32'(acc[31:16]);
        return ~acc[15:0];
    endfunction

    function automatic int predict_frames(input t_in_item it, output t_result r0,
                                          output t_result r1);
        int      cnt;
        t_result hdr;
        cnt = 0;
        r0  = '0;
        r1  = '0;
        hdr = '0;
        if (it.mode == MODE_ARP_RX) begin
            if (it.hw_type_low == ARP_HW_ETH && it.proto_type == ARP_PROTO_IPV4) begin
                if (it.arp_opcode == ARP_OP_REQUEST) begin
                    r0.kind     = KIND_ARP_REPLY;
                    r0.dest_mac = it.sender_mac;
                    r0.dest_ip  = it.sender_ip;
                    r0.last     = 1'b1;
                    cnt = 1;
                end else if (it.arp_opcode == ARP_OP_REPLY && m_pending
                             && it.sender_ip == m_cache_ip) begin
                    m_cache_mac = it.sender_mac;
                    m_pending   = 1'b0;
                end
            end
        end else begin
            if (it.target_ip == IP_BCAST) begin
                m_cache_ip  = IP_BCAST;
                m_cache_mac = MAC_BCAST;
            end
            if (it.target_ip != m_cache_ip && !m_pending) begin
                m_pending   = 1'b1;
                m_cache_ip  = it.target_ip;
                r0.kind     = KIND_ARP_REQ;
                r0.dest_mac = MAC_BCAST;
                r0.dest_ip  = it.target_ip;
                cnt = 1;
            end
            hdr.kind         = KIND_IPV4_HDR;
            hdr.dest_mac     = m_cache_mac;
            hdr.dest_ip      = m_cache_ip;
            hdr.total_length = it.payload_length + IP_HDR_BYTES;
            hdr.ident        = m_ident;
            hdr.protocol_out = it.ip_protocol;
            hdr.checksum     = hdr_csum(hdr.total_length, m_ident, it.ip_protocol, m_cache_ip);
            hdr.last         = 1'b1;
            m_ident = m_ident + 16'd1;
            if (cnt == 0) r0 = hdr;
            else r1 = hdr;
            cnt++;
        end
        return cnt;
    endfunction

    function automatic t_in_item arp_rx(input logic [7:0] hw, input logic [15:0] pt,
                                        input logic [15:0] op, input logic [47:0] smac,
                                        input logic [31:0] sip);
        t_in_item it;
        it             = '0;
        it.mode        = MODE_ARP_RX;
        it.hw_type_low = hw;
        it.proto_type  = pt;
        it.arp_opcode  = op;
        it.sender_mac  = smac;
        it.sender_ip   = sip;
        return it;
    endfunction

    function automatic t_in_item ip_tx(input logic [7:0] prot, input logic [31:0] tip,
                                       input logic [15:0] plen);
        t_in_item it;
        it                = '0;
        it.mode           = MODE_IP_TX;
        it.ip_protocol    = prot;
        it.target_ip      = tip;
        it.payload_length = plen;
        return it;
    endfunction

    function automatic t_result arp_reply_of(input logic [47:0] smac, input logic [31:0] sip);
        t_result r;
        r          = '0;
        r.kind     = KIND_ARP_REPLY;
        r.dest_mac = smac;
        r.dest_ip  = sip;
        r.last     = 1'b1;
        return r;
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        int       sel;
        int       pick;
        it.mode           = 1'($urandom);
        it.hw_type_low    = 8'($urandom);
        it.proto_type     = 16'($urandom);
        it.arp_opcode     = 16'($urandom);
        it.sender_mac     = 48'({$urandom, $urandom});
        it.sender_ip      = $urandom;
        it.ip_protocol    = 8'($urandom);
        it.target_ip      = $urandom;
        it.payload_length = 16'($urandom);
        sel  = $urandom_range(0, 99);
        pick = $urandom_range(0, 9);
        if (sel < 35) begin
            it.mode = MODE_IP_TX;
            if (pick < 7) it.target_ip = ip_pool[$urandom_range(0, 3)];
            else if (pick < 9) it.target_ip = IP_BCAST;
            if ($urandom_range(0, 3) != 0) it.payload_length = 16'($urandom_range(0, 1500));
        end else if (sel < 88) begin
            it.mode        = MODE_ARP_RX;
            it.hw_type_low = ARP_HW_ETH;
            it.proto_type  = ARP_PROTO_IPV4;
            it.arp_opcode  = (sel >= 60 && sel < 75) ? ARP_OP_REQUEST : ARP_OP_REPLY;
            if (pick < 8) it.sender_ip = ip_pool[$urandom_range(0, 3)];
            // malformed packets
            if (sel >= 75) begin
                case (pick % 3)
                    0: it.hw_type_low ^= 8'(1 << $urandom_range(0, 7));
                    1: it.proto_type ^= 16'(1 << $urandom_range(0, 15));
                    default: it.arp_opcode = 16'($urandom_range(3, 65535));
                endcase
            end
        end
        return it;
    endfunction

    function automatic string fmt_result(input t_result r);
        return $sformatf("kind %0d mac %h ip %h len %h id %h prot %h csum %h last %b",
                         r.kind, r.dest_mac, r.dest_ip, r.total_length, r.ident,
                         r.protocol_out, r.checksum, r.last);
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_result     want;
        t_result     r0;
        t_result     r1;
        t_typed_note note;
        int          n_pred;
        if (i_rst_n) begin
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                if (frames_due.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected result beat: %s", fmt_result(res_if.data));
                end else begin
                    want = frames_due.pop_front();
                    if (res_if.data.kind !== want.kind
                        || res_if.data.dest_mac !== want.dest_mac
                        || res_if.data.dest_ip !== want.dest_ip
                        || res_if.data.total_length !== want.total_length
                        || res_if.data.ident !== want.ident
                        || res_if.data.protocol_out !== want.protocol_out
                        || res_if.data.checksum !== want.checksum
                        || res_if.data.last !== want.last) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $display("result beat differs at cycle %0d", cycle_cnt);
                            $display("  expected %s", fmt_result(want));
                            $display("  actual   %s", fmt_result(res_if.data));
                        end
                    end
                end
            end
            if (i_cfg_we === 1'b1) begin
                case (i_cfg_index)
                    CFG_DEVICE_IP:  cfg_ip  = i_cfg_data[31:0];
                    CFG_DEVICE_MAC: cfg_mac = i_cfg_data;
                    CFG_TTL:        cfg_ttl = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (item_if.valid === 1'b1 && item_if.ready === 1'b1) begin
                note   = typed_notes.pop_front();
                n_pred = predict_frames(item_if.data, r0, r1);
                if (note.n == PREDICTED) begin
                    if (n_pred > 0) frames_due.push_back(r0);
                    if (n_pred > 1) frames_due.push_back(r1);
                end else if (note.n == 1) begin
                    frames_due.push_back(note.r);
                end
            end
        end
    end

    // result sink: random stall bursts, optional long hold-off
    initial begin : sink_ready
        int left;
        left = 0;
        res_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req     <= 1'b0;
                res_if.ready <= 1'b0;
                left = 150;
            end else if (left > 0) begin
                left--;
            end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
                res_if.ready <= 1'b0;
                left = $urandom_range(0, 6);
            end else begin
                res_if.ready <= 1'b1;
                if (!sink_idle_on) left = 0;
                else if ($urandom_range(0, 7) == 0) left = 40;
                else left = $urandom_range(0, 11);
            end
        end
    end

    task automatic add_row(input t_in_item it, input int n, input t_result r);
        t_dir_row row;
        row.it = it;
        row.n  = n;
        row.r  = r;
        dir_rows.push_back(row);
    endtask

    task automatic send(input t_in_item it, input int n, input t_result r, input bit no_gap);
        t_typed_note note;
        note.n = n;
        note.r = r;
        typed_notes.push_back(note);
        if (src_idle_on && !no_gap && $urandom_range(0, 3) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.data  <= it;
        @(posedge i_clk);
        while (item_if.ready !== 1'b1) @(posedge i_clk);
    endtask

    task automatic wait_results();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (frames_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic settle();
        wait_results();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [31:0] ip, input logic [47:0] mac,
                              input logic [7:0] ttl);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DEVICE_IP;
        i_cfg_data  <= {16'($urandom), ip};
        @(posedge i_clk);
        i_cfg_index <= CFG_DEVICE_MAC;
        i_cfg_data  <= mac;
        @(posedge i_clk);
        i_cfg_index <= CFG_TTL;
        i_cfg_data  <= {8'($urandom), $urandom, ttl};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int count, input bit with_hold);
        int i;
        int rush;
        rush = 0;
        foreach (ip_pool[k]) ip_pool[k] = $urandom;
        for (i = 0; i < count; i++) begin
            if (with_hold && i == count / 4) begin
                hold_req <= 1'b1;
                rush = 40;
            end
            if (i == count / 2) wait_results();
            send(rand_item(), PREDICTED, '0, rush > 0);
            if (rush > 0) rush--;
        end
    endtask

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_DEVICE_IP;
        i_cfg_data    <= '0;
        item_if.valid <= 1'b0;
        item_if.data  <= '0;

        add_row(arp_rx(ARP_HW_ETH, ARP_PROTO_IPV4, ARP_OP_REQUEST, MAC_BCAST, 32'h0),
                1, arp_reply_of(MAC_BCAST, 32'h0));
        add_row(arp_rx(8'h00, ARP_PROTO_IPV4, ARP_OP_REQUEST, 48'h0, 32'h0A00_0001), 0, '0);
        add_row(arp_rx(8'hFF, ARP_PROTO_IPV4, ARP_OP_REQUEST, 48'h0, 32'h0A00_0001), 0, '0);
        add_row(arp_rx(ARP_HW_ETH, 16'hFFFF, ARP_OP_REQUEST, 48'h0, 32'h0A00_0001), 0, '0);
        add_row(arp_rx(ARP_HW_ETH, 16'h0000, ARP_OP_REQUEST, 48'h0, 32'h0A00_0001), 0, '0);
        add_row(arp_rx(ARP_HW_ETH, ARP_PROTO_IPV4, 16'h0000, 48'h0, 32'h0A00_0001), 0, '0);
        add_row(arp_rx(ARP_HW_ETH, ARP_PROTO_IPV4, 16'hFFFF, 48'h0, 32'h0A00_0001), 0, '0);
        add_row(arp_rx(ARP_HW_ETH, ARP_PROTO_IPV4, 16'h0003, 48'h0, 32'h0A00_0001), 0, '0);
        // reply with nothing pending
        add_row(arp_rx(ARP_HW_ETH, ARP_PROTO_IPV4, ARP_OP_REPLY, 48'h0200_0000_0001, 32'h0),
                0, '0);
        add_row(arp_rx(ARP_HW_ETH, ARP_PROTO_IPV4, ARP_OP_REQUEST, 48'h0, IP_BCAST),
                1, arp_reply_of(48'h0, IP_BCAST));
        add_row(ip_tx(8'h00, 32'h0, 16'h0000), PREDICTED, '0);
        add_row(ip_tx(8'h06, 32'hC0A8_0101, 16'd100), PREDICTED, '0);
        // pending: no new request, oversized payload wraps
        add_row(ip_tx(8'hFF, 32'h0A00_0002, 16'hFFFF), PREDICTED, '0);
        add_row(arp_rx(ARP_HW_ETH, ARP_PROTO_IPV4, ARP_OP_REPLY, 48'h0211_2233_4455,
                       32'h0A00_0002), 0, '0);
        add_row(arp_rx(8'h02, ARP_PROTO_IPV4, ARP_OP_REPLY, 48'h0211_2233_4455,
                       32'hC0A8_0101), 0, '0);
        add_row(arp_rx(ARP_HW_ETH, ARP_PROTO_IPV4, ARP_OP_REPLY, 48'h0211_2233_4455,
                       32'hC0A8_0101), 0, '0);
        add_row(ip_tx(8'h11, 32'hC0A8_0101, 16'd65515), PREDICTED, '0);
        add_row(arp_rx(ARP_HW_ETH, ARP_PROTO_IPV4, ARP_OP_REPLY, 48'hFEDC_BA98_7654,
                       32'hC0A8_0101), 0, '0);
        add_row(ip_tx(8'h01, IP_BCAST, 16'd20), PREDICTED, '0);
        add_row(ip_tx(8'h01, IP_BCAST, 16'd1), PREDICTED, '0);
        add_row(ip_tx(8'h11, 32'h0, 16'd0), PREDICTED, '0);
        add_row(ip_tx(8'h11, 32'h0, 16'hFFEC), PREDICTED, '0);
        add_row(arp_rx(ARP_HW_ETH, ARP_PROTO_IPV4, ARP_OP_REPLY, 48'h0, 32'h0), 0, '0);
        add_row(ip_tx(8'h00, 32'h0, 16'h0000), PREDICTED, '0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_idle_on = 1'b1;
        sink_idle_on <= 1'b1;

        foreach (dir_rows[k]) send(dir_rows[k].it, dir_rows[k].n, dir_rows[k].r, 1'b0);

        settle();
        write_regs(32'h0, 48'h0, 8'h00);
        run_phase(330, 1'b1);

        settle();
        write_regs(32'hFFFF_FFFF, MAC_BCAST, 8'hFF);
        run_phase(330, 1'b0);

        settle();
        write_regs($urandom, 48'({$urandom, $urandom}), 8'($urandom));
        run_phase(330, 1'b0);

        // last part: no idling on either side
        settle();
        src_idle_on = 1'b0;
        sink_idle_on <= 1'b0;
        write_regs($urandom, 48'({$urandom, $urandom}), 8'($urandom));
        run_phase(360, 1'b0);

        settle();
        if (err_cnt == 0 && frames_due.size() == 0) begin
            $display("arp_resolver_ipv4_header_builder: match");
        end else begin
            $display("arp_resolver_ipv4_header_builder: mismatch");
        end
        $finish;
    end

endmodule
